@@ sv/dpms_pkg.sv @@
package dpms_pkg;

	// field widths
	localparam int unsigned ALT_W      = 20;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned ACT_W      = 3;
	localparam int unsigned SLOT_W     = 2;
	localparam int unsigned TYPE_W     = 2;
	localparam int unsigned PARAM_W    = 20;
	localparam int unsigned WGT_W      = 32;
	localparam int unsigned SIDX_W     = 16;
	localparam int unsigned DENS_W     = 17;
	localparam int unsigned ERR_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 20;

	localparam int unsigned MAX_MODES_DEF       = 4;
	localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;

	localparam logic [ALT_W-1:0]  MIN_ALT_RST  = 20'd0;
	localparam logic [ALT_W-1:0]  MAX_ALT_RST  = 20'd80000;
	localparam logic [CNT_W-1:0]  COUNT_RST    = 16'd1024;
	localparam logic [ACT_W-1:0]  ACTIVE_RST   = 3'd1;

	localparam logic [DENS_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [63:0]       LN2_Q32   = 64'd2977044472;
	localparam logic [30:0]       LOG2E_Q30 = 31'd1549082005;

	typedef enum logic [0:0] {
		KIND_LOAD   = 1'b0,
		KIND_SAMPLE = 1'b1
	} item_kind_t;

	typedef enum logic [TYPE_W-1:0] {
		MODE_EXP  = 2'd0,
		MODE_DEXP = 2'd1,
		MODE_TENT = 2'd2
	} mode_type_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK          = 2'd0,
		ERR_NO_MODES    = 2'd1,
		ERR_ZERO_WEIGHT = 2'd2,
		ERR_BAD_COUNT   = 2'd3
	} err_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_ALT = 2'd0,
		CFG_MAX_ALT = 2'd1,
		CFG_COUNT   = 2'd2,
		CFG_ACTIVE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_START,
		OP_TOTAL,
		OP_CHECK,
		OP_ALT_MUL,
		OP_DIV_ALT,
		OP_ALT_FIN,
		OP_MODE_ONE,
		OP_MODE_ZERO,
		OP_DIV_MODE,
		OP_MODE_POST,
		OP_EXP_MUL,
		OP_POS_NEG,
		OP_POS_POS,
		OP_TAB,
		OP_INTERP,
		OP_EXP_RND,
		OP_EXP_FIN,
		OP_ACC,
		OP_DIV_MEAN,
		OP_MEAN_FIN,
		OP_PUT
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TOTAL,
		S_CHECK,
		S_ALT_MUL,
		S_ALT_DIV,
		S_ALT_WAIT,
		S_ALT_FIN,
		S_MODE,
		S_MDIV_WAIT,
		S_MODE_POST,
		S_EN_MUL,
		S_EN_POS,
		S_EN_TAB,
		S_EN_INT,
		S_EN_RND,
		S_EP_MUL,
		S_EP_POS,
		S_EP_TAB,
		S_EP_INT,
		S_EP_FIN,
		S_ACC,
		S_MEAN_DIV,
		S_MEAN_WAIT,
		S_MEAN_FIN,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		dp_op_t op;
	} dpms_cmd_t;

	typedef struct packed {
		logic              m_end;
		logic [TYPE_W-1:0] kind;
		logic              alt_neg;
		logic              err_now;
		logic              div_done;
		logic              big;
		logic              out_free;
	} dpms_stat_t;

endpackage

@@ sv/dpms_item_if.sv @@
interface dpms_item_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic [dpms_pkg::SLOT_W-1:0]       mode_slot;
	logic [dpms_pkg::TYPE_W-1:0]       mode_type;
	logic [dpms_pkg::PARAM_W-1:0]      param_a;
	logic [dpms_pkg::PARAM_W-1:0]      param_b;
	logic [dpms_pkg::WGT_W-1:0]        mode_weight;
	logic [dpms_pkg::SIDX_W-1:0]       sample_index;

	modport source (output valid, kind, mode_slot, mode_type, param_a, param_b,
		mode_weight, sample_index, input ready);
	modport sink (input valid, kind, mode_slot, mode_type, param_a, param_b,
		mode_weight, sample_index, output ready);
endinterface

@@ sv/dpms_result_if.sv @@
interface dpms_result_if;
	logic                          valid;
	logic                          ready;
	logic [dpms_pkg::DENS_W-1:0]   density;
	logic [dpms_pkg::SIDX_W-1:0]   echo_index;
	logic [dpms_pkg::ERR_W-1:0]    error_code;

	modport source (output valid, density, echo_index, error_code, input ready);
	modport sink (input valid, density, echo_index, error_code, output ready);
endinterface

@@ sv/dpms_divider.sv @@
module dpms_divider #(
	parameter int unsigned NW = 54,
	parameter int unsigned DW = 35
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] work_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, work_q[NW-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (cnt_q != '0) begin
			if (fits) begin
				rem_q  <= DW'(trial - {1'b0, den_q});
				work_q <= {work_q[NW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DW-1:0];
				work_q <= {work_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = work_q;
endmodule

@@ sv/dpms_datapath.sv @@
module dpms_datapath #(
	parameter int unsigned MAX_MODES       = dpms_pkg::MAX_MODES_DEF,
	parameter int unsigned EXP_TABLE_DEPTH = dpms_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpms_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic [dpms_pkg::SLOT_W-1:0]       mode_slot,
	input  logic [dpms_pkg::TYPE_W-1:0]       mode_type,
	input  logic [dpms_pkg::PARAM_W-1:0]      param_a,
	input  logic [dpms_pkg::PARAM_W-1:0]      param_b,
	input  logic [dpms_pkg::WGT_W-1:0]        mode_weight,
	input  logic [dpms_pkg::SIDX_W-1:0]       sample_index,
	input  dpms_pkg::dpms_cmd_t               cmd,
	output dpms_pkg::dpms_stat_t              stat,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [dpms_pkg::DENS_W-1:0]       res_density,
	output logic [dpms_pkg::SIDX_W-1:0]       res_index,
	output logic [dpms_pkg::ERR_W-1:0]        res_error
);
	localparam int unsigned MIW   = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
	localparam int unsigned MCW   = $clog2(MAX_MODES + 1);
	localparam int unsigned TOT_W = 32 + MCW;
	localparam int unsigned SUM_W = 48 + MCW;
	localparam int unsigned NUM_W = (SUM_W + 1 > 54) ? SUM_W + 1 : 54;
	localparam int unsigned AW    = NUM_W;
	localparam int unsigned TIW   = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int unsigned PW    = 16 + TIW;
	localparam int unsigned PAW   = dpms_pkg::PARAM_W;

	typedef logic [30:0] pow2_tab_t [0:EXP_TABLE_DEPTH];

	// 2^-(j/depth) in Q30 by the series of exp(-u) up to the u^14 term, u = j*ln2/depth
	function automatic pow2_tab_t build_tab();
		pow2_tab_t          tab;
		logic [63:0]        u;
		logic [63:0]        term;
		logic signed [65:0] s;
		for (int unsigned j = 0; j <= EXP_TABLE_DEPTH; j++) begin
			u    = (64'(j) * dpms_pkg::LN2_Q32) / EXP_TABLE_DEPTH;
			term = 64'd1 << 32;
			s    = 66'sd4294967296;
			for (int unsigned k = 1; k <= 14; k++) begin
				term = ((term * u) >> 32) / 64'(k);
				if (k % 2 == 1) begin
					s = s - $signed({2'b00, term});
				end else begin
					s = s + $signed({2'b00, term});
				end
			end
			if (s < 0) begin
				s = '0;
			end
			tab[j] = 31'((s + 66'sd2) >>> 2);
		end
		return tab;
	endfunction

	localparam pow2_tab_t POW2_TAB = build_tab();

	// configuration
	logic [dpms_pkg::ALT_W-1:0] min_alt_q, max_alt_q;
	logic [dpms_pkg::CNT_W-1:0] count_q;
	logic [dpms_pkg::ACT_W-1:0] act_modes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_alt_q   <= dpms_pkg::MIN_ALT_RST;
			max_alt_q   <= dpms_pkg::MAX_ALT_RST;
			count_q     <= dpms_pkg::COUNT_RST;
			act_modes_q <= dpms_pkg::ACTIVE_RST;
		end else if (cfg_we) begin
			case (dpms_pkg::cfg_idx_t'(cfg_index))
				dpms_pkg::CFG_MIN_ALT: min_alt_q   <= cfg_data[dpms_pkg::ALT_W-1:0];
				dpms_pkg::CFG_MAX_ALT: max_alt_q   <= cfg_data[dpms_pkg::ALT_W-1:0];
				dpms_pkg::CFG_COUNT:   count_q     <= cfg_data[dpms_pkg::CNT_W-1:0];
				dpms_pkg::CFG_ACTIVE:  act_modes_q <= cfg_data[dpms_pkg::ACT_W-1:0];
				default: ;
			endcase
		end
	end

	// mode table
	logic [dpms_pkg::TYPE_W-1:0] kind_mem [MAX_MODES];
	logic [PAW-1:0]              a_mem    [MAX_MODES];
	logic [PAW-1:0]              b_mem    [MAX_MODES];
	logic [dpms_pkg::WGT_W-1:0]  w_mem    [MAX_MODES];

	always_ff @(posedge clk) begin
		if (cmd.op == dpms_pkg::OP_LOAD && int'(mode_slot) < MAX_MODES) begin
			kind_mem[MIW'(mode_slot)] <= mode_type;
			a_mem[MIW'(mode_slot)]    <= param_a;
			b_mem[MIW'(mode_slot)]    <= param_b;
			w_mem[MIW'(mode_slot)]    <= mode_weight;
		end
	end

	logic [MCW-1:0]              m_q;
	logic [MIW-1:0]              mi;
	logic [MCW-1:0]              act;
	logic [dpms_pkg::TYPE_W-1:0] cur_kind;
	logic [PAW-1:0]              cur_a, cur_b;
	logic [dpms_pkg::WGT_W-1:0]  cur_w;

	assign mi       = m_q[MIW-1:0];
	assign act      = (int'(act_modes_q) > MAX_MODES) ? MCW'(MAX_MODES) : MCW'(act_modes_q);
	assign cur_kind = kind_mem[mi];
	assign cur_a    = a_mem[mi];
	assign cur_b    = b_mem[mi];
	assign cur_w    = w_mem[mi];

	logic [dpms_pkg::SIDX_W-1:0] idx_q;
	logic [TOT_W-1:0]            total_q;
	logic [SUM_W-1:0]            sum_q;
	dpms_pkg::err_code_t         err_q;
	logic [dpms_pkg::DENS_W-1:0] dens_q;
	logic [35:0]                 prod_q;
	logic [AW-1:0]               alt_q;
	logic [NUM_W-1:0]            x_q;
	logic [dpms_pkg::DENS_W-1:0] d_q;
	logic [21:0]                 y_q;
	logic                        zero_q;
	logic [TIW-1:0]              tidx_q;
	logic [15:0]                 fr_q;
	logic [30:0]                 ta_q, tb_q, v_q;

	// divider operands
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num, div_quot;
	logic [TOT_W-1:0] div_den;
	logic [AW-1:0]    tent_d, tent_mag;
	logic [PAW-1:0]   a_nz, b_nz;
	logic             desc;
	logic [PAW-1:0]   span;

	assign desc     = (max_alt_q < min_alt_q);
	assign span     = desc ? (min_alt_q - max_alt_q) : (max_alt_q - min_alt_q);
	assign a_nz     = (cur_a == '0) ? PAW'(1) : cur_a;
	assign b_nz     = (cur_b == '0) ? PAW'(1) : cur_b;
	assign tent_d   = alt_q - AW'({cur_a, 16'h0000});
	assign tent_mag = tent_d[AW-1] ? (~tent_d + AW'(1)) : tent_d;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = TOT_W'(1);
		case (cmd.op)
			dpms_pkg::OP_DIV_ALT: begin
				div_start = 1'b1;
				div_num   = NUM_W'({prod_q, 16'h0000});
				div_den   = TOT_W'(count_q - 1'b1);
			end
			dpms_pkg::OP_DIV_MODE: begin
				div_start = 1'b1;
				if (cur_kind == dpms_pkg::MODE_TENT) begin
					div_num = NUM_W'(tent_mag);
					div_den = TOT_W'(b_nz);
				end else begin
					div_num = NUM_W'(alt_q);
					div_den = TOT_W'(a_nz);
				end
			end
			dpms_pkg::OP_DIV_MEAN: begin
				div_start = 1'b1;
				div_num   = NUM_W'(sum_q) + NUM_W'(total_q >> 1);
				div_den   = total_q;
			end
			default: ;
		endcase
	end

	dpms_divider #(
		.NW (NUM_W),
		.DW (TOT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// exponential helpers
	logic [51:0]        y_prod;
	logic [15:0]        f_neg, f_pos;
	logic [PW-1:0]      pos_neg, pos_pos;
	logic [5:0]         n_exp;
	logic [5:0]         sh;
	logic [31:0]        rnd;
	logic [31:0]        rounded;
	logic [46:0]        ip_prod;
	logic [36:0]        ex;
	logic [36:0]        ex_m1;

	assign y_prod  = 52'(x_q[20:0]) * 52'(dpms_pkg::LOG2E_Q30);
	assign n_exp   = y_q[21:16];
	assign f_neg   = y_q[15:0];
	assign f_pos   = 16'(17'h10000 - 17'(y_q[15:0]));
	assign pos_neg = PW'(f_neg) * PW'(EXP_TABLE_DEPTH);
	assign pos_pos = PW'(f_pos) * PW'(EXP_TABLE_DEPTH);
	assign sh      = 6'd14 + n_exp;
	assign rnd     = 32'd1 << (sh - 6'd1);
	assign rounded = (32'(v_q) + rnd) >> sh;
	assign ip_prod = 47'(ta_q - tb_q) * 47'(fr_q);
	assign ex      = (y_q[15:0] == '0) ? (37'h40000000 << n_exp)
		: (37'(v_q) << (n_exp + 6'd1));
	assign ex_m1   = (ex - 37'h40000000) >> 14;

	logic [dpms_pkg::DENS_W-1:0] tent_dens;
	assign tent_dens = (div_quot >= NUM_W'(dpms_pkg::ONE_Q16)) ? '0
		: dpms_pkg::ONE_Q16 - div_quot[dpms_pkg::DENS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= '0;
		end else begin
			case (cmd.op)
				dpms_pkg::OP_START, dpms_pkg::OP_CHECK: m_q <= '0;
				dpms_pkg::OP_TOTAL, dpms_pkg::OP_ACC:   m_q <= m_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			dpms_pkg::OP_START: begin
				idx_q   <= sample_index;
				total_q <= '0;
				sum_q   <= '0;
				err_q   <= dpms_pkg::ERR_OK;
			end
			dpms_pkg::OP_TOTAL: total_q <= total_q + TOT_W'(cur_w);
			dpms_pkg::OP_CHECK: begin
				dens_q <= '0;
				if (count_q < 16'd2) begin
					err_q <= dpms_pkg::ERR_BAD_COUNT;
				end else if (act == '0) begin
					err_q <= dpms_pkg::ERR_NO_MODES;
				end else if (total_q == '0) begin
					err_q <= dpms_pkg::ERR_ZERO_WEIGHT;
				end else begin
					err_q <= dpms_pkg::ERR_OK;
				end
			end
			dpms_pkg::OP_ALT_MUL: prod_q <= 36'(idx_q) * 36'(span);
			dpms_pkg::OP_ALT_FIN: begin
				if (desc) begin
					alt_q <= AW'({min_alt_q, 16'h0000}) - AW'(div_quot);
				end else begin
					alt_q <= AW'({min_alt_q, 16'h0000}) + AW'(div_quot);
				end
			end
			dpms_pkg::OP_MODE_ONE:  d_q <= dpms_pkg::ONE_Q16;
			dpms_pkg::OP_MODE_ZERO: d_q <= '0;
			dpms_pkg::OP_MODE_POST: begin
				x_q <= div_quot;
				if (cur_kind == dpms_pkg::MODE_TENT) begin
					d_q <= tent_dens;
				end else begin
					d_q <= '0;
				end
			end
			dpms_pkg::OP_EXP_MUL: begin
				y_q    <= y_prod[51:30];
				zero_q <= (x_q[NUM_W-1:21] != '0);
			end
			dpms_pkg::OP_POS_NEG: begin
				tidx_q <= pos_neg[PW-1:16];
				fr_q   <= pos_neg[15:0];
			end
			dpms_pkg::OP_POS_POS: begin
				tidx_q <= pos_pos[PW-1:16];
				fr_q   <= pos_pos[15:0];
			end
			dpms_pkg::OP_TAB: begin
				ta_q <= POW2_TAB[tidx_q];
				tb_q <= POW2_TAB[tidx_q + TIW'(1)];
			end
			dpms_pkg::OP_INTERP: begin
				if (ta_q < tb_q) begin
					v_q <= ta_q;
				end else begin
					v_q <= ta_q - ip_prod[46:16];
				end
			end
			dpms_pkg::OP_EXP_RND: begin
				if (zero_q || n_exp > 6'd16) begin
					d_q <= '0;
				end else begin
					d_q <= rounded[dpms_pkg::DENS_W-1:0];
				end
			end
			dpms_pkg::OP_EXP_FIN: begin
				if (ex <= 37'h40000000) begin
					x_q <= '0;
				end else begin
					x_q <= NUM_W'(ex_m1);
				end
			end
			dpms_pkg::OP_ACC: sum_q <= sum_q + SUM_W'(49'(cur_w) * 49'(d_q));
			dpms_pkg::OP_MEAN_FIN: begin
				if (div_quot > NUM_W'(dpms_pkg::ONE_Q16)) begin
					dens_q <= dpms_pkg::ONE_Q16;
				end else begin
					dens_q <= div_quot[dpms_pkg::DENS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// result register, parts the output side from the work in progress
	logic                        res_valid_q;
	logic [dpms_pkg::DENS_W-1:0] res_dens_q;
	logic [dpms_pkg::SIDX_W-1:0] res_idx_q;
	logic [dpms_pkg::ERR_W-1:0]  res_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.op == dpms_pkg::OP_PUT) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == dpms_pkg::OP_PUT) begin
			res_dens_q <= dens_q;
			res_idx_q  <= idx_q;
			res_err_q  <= err_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign res_density = res_dens_q;
	assign res_index   = res_idx_q;
	assign res_error   = res_err_q;

	assign stat.m_end    = (m_q == act);
	assign stat.kind     = cur_kind;
	assign stat.alt_neg  = alt_q[AW-1];
	assign stat.err_now  = (count_q < 16'd2) || (act == '0) || (total_q == '0);
	assign stat.div_done = div_done;
	assign stat.big      = (div_quot[NUM_W-1:18] != '0);
	assign stat.out_free = !res_valid_q || res_ready;
endmodule

@@ sv/dpms_ctrl.sv @@
module dpms_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_kind,
	output logic                 item_ready,
	input  dpms_pkg::dpms_stat_t stat,
	output dpms_pkg::dpms_cmd_t  cmd
);
	dpms_pkg::ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpms_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dpms_pkg::S_IDLE: begin
				if (item_valid && item_kind == dpms_pkg::KIND_SAMPLE) begin
					state_nx = dpms_pkg::S_TOTAL;
				end
			end
			dpms_pkg::S_TOTAL: begin
				if (stat.m_end) begin
					state_nx = dpms_pkg::S_CHECK;
				end
			end
			dpms_pkg::S_CHECK: state_nx = stat.err_now ? dpms_pkg::S_OUT : dpms_pkg::S_ALT_MUL;
			dpms_pkg::S_ALT_MUL: state_nx = dpms_pkg::S_ALT_DIV;
			dpms_pkg::S_ALT_DIV: state_nx = dpms_pkg::S_ALT_WAIT;
			dpms_pkg::S_ALT_WAIT: begin
				if (stat.div_done) begin
					state_nx = dpms_pkg::S_ALT_FIN;
				end
			end
			dpms_pkg::S_ALT_FIN: state_nx = dpms_pkg::S_MODE;
			dpms_pkg::S_MODE: begin
				if (stat.m_end) begin
					state_nx = dpms_pkg::S_MEAN_DIV;
				end else if (stat.kind == dpms_pkg::MODE_TENT) begin
					state_nx = dpms_pkg::S_MDIV_WAIT;
				end else if (stat.kind == dpms_pkg::MODE_EXP
						|| stat.kind == dpms_pkg::MODE_DEXP) begin
					state_nx = stat.alt_neg ? dpms_pkg::S_ACC : dpms_pkg::S_MDIV_WAIT;
				end else begin
					state_nx = dpms_pkg::S_ACC;
				end
			end
			dpms_pkg::S_MDIV_WAIT: begin
				if (stat.div_done) begin
					state_nx = dpms_pkg::S_MODE_POST;
				end
			end
			dpms_pkg::S_MODE_POST: begin
				if (stat.kind == dpms_pkg::MODE_EXP) begin
					state_nx = dpms_pkg::S_EN_MUL;
				end else if (stat.kind == dpms_pkg::MODE_DEXP && !stat.big) begin
					state_nx = dpms_pkg::S_EP_MUL;
				end else begin
					state_nx = dpms_pkg::S_ACC;
				end
			end
			dpms_pkg::S_EP_MUL: state_nx = dpms_pkg::S_EP_POS;
			dpms_pkg::S_EP_POS: state_nx = dpms_pkg::S_EP_TAB;
			dpms_pkg::S_EP_TAB: state_nx = dpms_pkg::S_EP_INT;
			dpms_pkg::S_EP_INT: state_nx = dpms_pkg::S_EP_FIN;
			dpms_pkg::S_EP_FIN: state_nx = dpms_pkg::S_EN_MUL;
			dpms_pkg::S_EN_MUL: state_nx = dpms_pkg::S_EN_POS;
			dpms_pkg::S_EN_POS: state_nx = dpms_pkg::S_EN_TAB;
			dpms_pkg::S_EN_TAB: state_nx = dpms_pkg::S_EN_INT;
			dpms_pkg::S_EN_INT: state_nx = dpms_pkg::S_EN_RND;
			dpms_pkg::S_EN_RND: state_nx = dpms_pkg::S_ACC;
			dpms_pkg::S_ACC: state_nx = dpms_pkg::S_MODE;
			dpms_pkg::S_MEAN_DIV: state_nx = dpms_pkg::S_MEAN_WAIT;
			dpms_pkg::S_MEAN_WAIT: begin
				if (stat.div_done) begin
					state_nx = dpms_pkg::S_MEAN_FIN;
				end
			end
			dpms_pkg::S_MEAN_FIN: state_nx = dpms_pkg::S_OUT;
			dpms_pkg::S_OUT: begin
				if (stat.out_free) begin
					state_nx = dpms_pkg::S_IDLE;
				end
			end
			default: state_nx = dpms_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op     = dpms_pkg::OP_NOP;
		item_ready = 1'b0;
		case (state_q)
			dpms_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.op = (item_kind == dpms_pkg::KIND_SAMPLE) ? dpms_pkg::OP_START
						: dpms_pkg::OP_LOAD;
				end
			end
			dpms_pkg::S_TOTAL: begin
				if (!stat.m_end) begin
					cmd.op = dpms_pkg::OP_TOTAL;
				end
			end
			dpms_pkg::S_CHECK:   cmd.op = dpms_pkg::OP_CHECK;
			dpms_pkg::S_ALT_MUL: cmd.op = dpms_pkg::OP_ALT_MUL;
			dpms_pkg::S_ALT_DIV: cmd.op = dpms_pkg::OP_DIV_ALT;
			dpms_pkg::S_ALT_FIN: cmd.op = dpms_pkg::OP_ALT_FIN;
			dpms_pkg::S_MODE: begin
				if (stat.m_end) begin
					cmd.op = dpms_pkg::OP_NOP;
				end else if (stat.kind == dpms_pkg::MODE_TENT) begin
					cmd.op = dpms_pkg::OP_DIV_MODE;
				end else if (stat.kind == dpms_pkg::MODE_EXP
						|| stat.kind == dpms_pkg::MODE_DEXP) begin
					cmd.op = stat.alt_neg ? dpms_pkg::OP_MODE_ONE : dpms_pkg::OP_DIV_MODE;
				end else begin
					cmd.op = dpms_pkg::OP_MODE_ZERO;
				end
			end
			dpms_pkg::S_MODE_POST: cmd.op = dpms_pkg::OP_MODE_POST;
			dpms_pkg::S_EP_MUL, dpms_pkg::S_EN_MUL: cmd.op = dpms_pkg::OP_EXP_MUL;
			dpms_pkg::S_EP_POS: cmd.op = dpms_pkg::OP_POS_POS;
			dpms_pkg::S_EN_POS: cmd.op = dpms_pkg::OP_POS_NEG;
			dpms_pkg::S_EP_TAB, dpms_pkg::S_EN_TAB: cmd.op = dpms_pkg::OP_TAB;
			dpms_pkg::S_EP_INT, dpms_pkg::S_EN_INT: cmd.op = dpms_pkg::OP_INTERP;
			dpms_pkg::S_EP_FIN: cmd.op = dpms_pkg::OP_EXP_FIN;
			dpms_pkg::S_EN_RND: cmd.op = dpms_pkg::OP_EXP_RND;
			dpms_pkg::S_ACC:      cmd.op = dpms_pkg::OP_ACC;
			dpms_pkg::S_MEAN_DIV: cmd.op = dpms_pkg::OP_DIV_MEAN;
			dpms_pkg::S_MEAN_FIN: cmd.op = dpms_pkg::OP_MEAN_FIN;
			dpms_pkg::S_OUT: begin
				if (stat.out_free) begin
					cmd.op = dpms_pkg::OP_PUT;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// the divider only finishes while a wait state listens for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		stat.div_done |-> (state_q == dpms_pkg::S_ALT_WAIT
			|| state_q == dpms_pkg::S_MDIV_WAIT || state_q == dpms_pkg::S_MEAN_WAIT))
		else $error("divider finished outside a wait state");

	// a word is only handed to the result register when it has room
	a_put_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == dpms_pkg::OP_PUT |-> stat.out_free)
		else $error("result overwritten");

	// the mode walk never runs past the active count
	a_acc_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dpms_pkg::S_ACC |-> !stat.m_end)
		else $error("accumulate past last mode");

	// a sample always leads into the weight sum
	a_start_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == dpms_pkg::OP_START |=> state_q == dpms_pkg::S_TOTAL)
		else $error("sample not started");
`endif
endmodule

@@ sv/density_profile_mixture_sampler.sv @@
// Load word: written into the mode table slot it names, no result.
// Sample word: the block sums the weights of the N active modes and works out the altitude; then
// each mode gets a division (tent, or exponential above zero altitude) and for an exponential the
// table lookups where needed, and a division for the weighted mean ends it. Errors go out after the check.
// One sample in work at a time; a finished result waits in an output register.
// Reset (arst_n low, asynchronous) restores the configuration defaults; the mode table is not reset.
module density_profile_mixture_sampler #(
	parameter int unsigned MAX_MODES       = dpms_pkg::MAX_MODES_DEF,
	parameter int unsigned EXP_TABLE_DEPTH = dpms_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dpms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dpms_pkg::CFG_DATA_W-1:0]   cfg_data,
	dpms_item_if.sink                         items,
	dpms_result_if.source                     results
);
	dpms_pkg::dpms_cmd_t  cmd;
	dpms_pkg::dpms_stat_t stat;
	logic                 item_ready;

	assign items.ready = item_ready;

	dpms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (items.valid),
		.item_kind  (items.kind),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	dpms_datapath #(
		.MAX_MODES       (MAX_MODES),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode_slot    (items.mode_slot),
		.mode_type    (items.mode_type),
		.param_a      (items.param_a),
		.param_b      (items.param_b),
		.mode_weight  (items.mode_weight),
		.sample_index (items.sample_index),
		.cmd          (cmd),
		.stat         (stat),
		.res_valid    (results.valid),
		.res_ready    (results.ready),
		.res_density  (results.density),
		.res_index    (results.echo_index),
		.res_error    (results.error_code)
	);
endmodule
